[rtl/deadline_timer_queue_unit_macros.svh]
// Assertion macros for the deadline timer queue.
// Included by the modules that carry concurrent checks; each expects clk and rst_n in scope.
`ifndef DEADLINE_TIMER_QUEUE_UNIT_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent
`define DTQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent
`define DTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DTQ_ASSERT_SAME(lbl, ante, cons, msg)
`define DTQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/dtq_pkg.sv]
// Shared constants, codes and types for the deadline timer queue.
// No dependencies; imported by the channel interfaces and the top level.
`timescale 1ns / 1ps

package dtq_pkg;

  // Sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int MAX_RESULTS = 16;

  // Fixed field widths
  localparam int TIME_W  = 32;
  localparam int DELAY_W = 24;
  localparam int EXT_ID_W = 16;

  // Derived widths
  localparam int ID_KEEP = (ID_BITS < EXT_ID_W) ? ID_BITS : EXT_ID_W;
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int RW = $clog2(MAX_RESULTS + 1);

  // Request codes
  localparam logic REQ_SCHEDULE = 1'b0;
  localparam logic REQ_TICK     = 1'b1;

  // Result status codes
  localparam logic STAT_ON_TIME = 1'b0;
  localparam logic STAT_FULL    = 1'b1;

  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [ID_KEEP-1:0] id_t;

  // One stored timer entry
  typedef struct packed {
    time_t deadline;
    id_t   id;
  } entry_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_REL_RD,
    ST_REL_CMP,
    ST_EMIT
  } state_t;

endpackage

[rtl/dtq_if.sv]
// Valid/ready channel interfaces for the request and result beats.
// Depends on dtq_pkg for the field widths.
`timescale 1ns / 1ps

interface dtq_in_if import dtq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [DELAY_W-1:0] delay_ticks;
  logic [EXT_ID_W-1:0] entry_id;

  modport source (output valid, req_type, delay_ticks, entry_id, input ready);
  modport sink   (input valid, req_type, delay_ticks, entry_id, output ready);
endinterface

interface dtq_out_if import dtq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [EXT_ID_W-1:0] released_id;
  logic                status;
  logic                last_of_run;

  modport source (output valid, released_id, status, last_of_run, input ready);
  modport sink   (input valid, released_id, status, last_of_run, output ready);
endinterface

[rtl/deadline_timer_queue_unit.sv]
// Deadline timer queue: top level with the entry store and its sequencer.
// Depends on dtq_pkg, dtq_if and deadline_timer_queue_unit_macros.svh.
`timescale 1ns / 1ps
`include "deadline_timer_queue_unit_macros.svh"

// Holds up to QUEUE_DEPTH pending timers in a circular store sorted by deadline
// (head = earliest). A schedule beat with zero delay, or one that finds the store
// full, returns a single result; otherwise it is placed by insertion, walking from
// the tail and moving each later entry up one slot. A tick beat advances the
// 32-bit time and releases due entries from the head, up to MAX_RESULTS, marking
// the last one. One item is handled at a time. Each entry visited takes a read
// state and a compare state, and a result that cannot leave holds the sequencer.
// The single-read-port store (registered read) and the one shared wrapping-time
// comparator are each visited once per entry. The output register lets a result
// wait while the sequencer moves on to the next entry.

module deadline_timer_queue_unit
  import dtq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  dtq_in_if.sink    in_ch,
  dtq_out_if.source out_ch
);

  // Entry store, read data registered
  entry_t store_mem_r [QUEUE_DEPTH];
  entry_t rd_q_r;

  state_t              state_r, state_nxt;
  time_t               time_r, time_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [AW-1:0]       slot_r, slot_nxt;
  time_t               new_dl_r, new_dl_nxt;
  id_t                 new_id_r, new_id_nxt;
  id_t                 pend_id_r, pend_id_nxt;
  logic                pend_status_r, pend_status_nxt;
  logic                have_pend_r, have_pend_nxt;
  logic [RW-1:0]       n_rel_r, n_rel_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [EXT_ID_W-1:0] out_id_r, out_id_nxt;
  logic                out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          in_fire;
  logic          out_free;
  time_t         cmp_b;
  time_t         cmp_diff;
  logic          due_or_before;

  // Circular index: base plus offset, modulo the depth
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (AW+1)'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Shared comparator: stored deadline at or before the new deadline or the time
  assign cmp_b         = (state_r == ST_INS_CMP) ? new_dl_r : time_r;
  assign cmp_diff      = cmp_b - rd_q_r.deadline;
  assign due_or_before = !cmp_diff[TIME_W-1];

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= store_mem_r[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      time_r      <= '0;
      cnt_r       <= '0;
      head_r      <= '0;
      have_pend_r <= 1'b0;
      n_rel_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      have_pend_r <= have_pend_nxt;
      n_rel_r     <= n_rel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    slot_r        <= slot_nxt;
    new_dl_r      <= new_dl_nxt;
    new_id_r      <= new_id_nxt;
    pend_id_r     <= pend_id_nxt;
    pend_status_r <= pend_status_nxt;
    out_id_r      <= out_id_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
  end

  // Sequencer: next state, store access and result loading
  always_comb begin
    state_nxt       = state_r;
    time_nxt        = time_r;
    cnt_nxt         = cnt_r;
    head_nxt        = head_r;
    slot_nxt        = slot_r;
    new_dl_nxt      = new_dl_r;
    new_id_nxt      = new_id_r;
    pend_id_nxt     = pend_id_r;
    pend_status_nxt = pend_status_r;
    have_pend_nxt   = have_pend_r;
    n_rel_nxt       = n_rel_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_id_nxt      = out_id_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;
    rd_en           = 1'b0;
    rd_addr         = head_r;
    wr_en           = 1'b0;
    wr_addr         = head_r;
    wr_data         = rd_q_r;
    in_ch.ready     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_fire) begin
          if (in_ch.req_type == REQ_TICK) begin
            // Advance time, then release from the head
            time_nxt      = time_r + time_t'(1);
            n_rel_nxt     = '0;
            have_pend_nxt = 1'b0;
            state_nxt     = ST_REL_RD;
          end else if (in_ch.delay_ticks == '0) begin
            pend_id_nxt     = in_ch.entry_id[ID_KEEP-1:0];
            pend_status_nxt = STAT_ON_TIME;
            have_pend_nxt   = 1'b1;
            state_nxt       = ST_EMIT;
          end else if (cnt_r == CW'(QUEUE_DEPTH)) begin
            pend_id_nxt     = in_ch.entry_id[ID_KEEP-1:0];
            pend_status_nxt = STAT_FULL;
            have_pend_nxt   = 1'b1;
            state_nxt       = ST_EMIT;
          end else begin
            new_dl_nxt = time_r + time_t'(in_ch.delay_ticks);
            new_id_nxt = in_ch.entry_id[ID_KEEP-1:0];
            slot_nxt   = cnt_r[AW-1:0];
            state_nxt  = ST_INS_RD;
          end
        end
      end

      ST_INS_RD: begin
        if (slot_r == '0) begin
          // Reached the head: new entry goes first
          wr_en     = 1'b1;
          wr_addr   = head_r;
          wr_data   = '{deadline: new_dl_r, id: new_id_r};
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = ST_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = wrap_add(head_r, slot_r - AW'(1));
          state_nxt = ST_INS_CMP;
        end
      end

      ST_INS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = wrap_add(head_r, slot_r);
        if (due_or_before) begin
          // Stored entry is not later: place the new one behind it
          wr_data   = '{deadline: new_dl_r, id: new_id_r};
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = ST_IDLE;
        end else begin
          // Move the later entry up one slot
          wr_data   = rd_q_r;
          slot_nxt  = slot_r - AW'(1);
          state_nxt = ST_INS_RD;
        end
      end

      ST_REL_RD: begin
        if (cnt_r == '0 || n_rel_r == RW'(MAX_RESULTS)) begin
          state_nxt = have_pend_r ? ST_EMIT : ST_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = head_r;
          state_nxt = ST_REL_CMP;
        end
      end

      ST_REL_CMP: begin
        if (due_or_before) begin
          // Hold while the previous result cannot leave
          if (!have_pend_r || out_free) begin
            if (have_pend_r) begin
              out_valid_nxt  = 1'b1;
              out_id_nxt     = EXT_ID_W'(pend_id_r);
              out_status_nxt = STAT_ON_TIME;
              out_last_nxt   = 1'b0;
            end
            pend_id_nxt     = rd_q_r.id;
            pend_status_nxt = STAT_ON_TIME;
            have_pend_nxt   = 1'b1;
            head_nxt        = wrap_add(head_r, AW'(1));
            cnt_nxt         = cnt_r - CW'(1);
            n_rel_nxt       = n_rel_r + RW'(1);
            state_nxt       = ST_REL_RD;
          end
        end else begin
          state_nxt = have_pend_r ? ST_EMIT : ST_IDLE;
        end
      end

      ST_EMIT: begin
        // Drop the held result as the last of the run
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_id_nxt     = EXT_ID_W'(pend_id_r);
          out_status_nxt = pend_status_r;
          out_last_nxt   = 1'b1;
          have_pend_nxt  = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.released_id = out_id_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.last_of_run = out_last_r;

  // Checks
  `DTQ_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CW'(QUEUE_DEPTH), "entry count above depth")
  `DTQ_ASSERT_SAME(a_rel_bound, 1'b1, n_rel_r <= RW'(MAX_RESULTS), "too many releases per tick")
  `DTQ_ASSERT_NEXT(a_tick_adv, in_fire && in_ch.req_type == REQ_TICK, time_r == $past(time_r) + time_t'(1), "tick did not advance time")
  `DTQ_ASSERT_SAME(a_idle_nowr, state_r == ST_IDLE, !wr_en, "store written while idle")
  `DTQ_ASSERT_SAME(a_emit_pend, state_r == ST_EMIT, have_pend_r, "emit state without a held result")

endmodule
